FILE: rtl/bfi_pkg.sv
// Types, codes and constants shared by the bit field insert engine.
package bfi_pkg;

    localparam int WORD_BITS   = 32;
    localparam int STORE_WORDS = 256;
    localparam int ADDR_BITS   = $clog2(STORE_WORDS);
    localparam int SHIFT_BITS  = $clog2(WORD_BITS);
    localparam int COUNT_BITS  = 14;
    localparam int OFFSET_BITS = 13;
    localparam int SPAN_BITS   = COUNT_BITS + 1;
    localparam logic [SPAN_BITS-1:0] TOTAL_BITS = SPAN_BITS'(WORD_BITS * STORE_WORDS);
    localparam logic [SPAN_BITS-1:0] WORD_SPAN  = SPAN_BITS'(WORD_BITS);

    typedef logic [WORD_BITS-1:0] word_t;
    typedef logic [ADDR_BITS-1:0] addr_t;

    typedef enum logic [1:0] {
        OP_WRITE  = 2'd0,
        OP_READ   = 2'd1,
        OP_INSERT = 2'd2,
        OP_NONE   = 2'd3
    } op_t;

    typedef enum logic [3:0] {
        S_IDLE  = 4'b0001,
        S_READ  = 4'b0010,
        S_MERGE = 4'b0100,
        S_TAIL  = 4'b1000
    } state_t;

    typedef struct packed {
        logic [1:0]             op;
        logic [7:0]             word_index;
        logic [31:0]            data;
        logic [OFFSET_BITS-1:0] bit_offset;
        logic [COUNT_BITS-1:0]  bit_count;
        logic                   first;
    } in_word_t;

    typedef struct packed {
        logic [31:0] read_data;
        logic        insert_done;
        logic        error;
    } out_word_t;

    typedef struct packed {
        logic  ok;
        logic  done;
        logic  tail;
        addr_t dest;
        word_t val;
        word_t mask;
        word_t tail_val;
        word_t tail_mask;
    } plan_t;

endpackage

FILE: rtl/bit_field_insert_engine.sv
// Top level of the bit field insert engine: sequencer, store and result register.
// Sequence: a write, an unused op or a rejected insert word answers from idle through the
// result register; a read passes S_READ, and an insert word S_MERGE and then S_TAIL when it
// also updates the trailing word. A new word is accepted only while busy is low.
// busy is high while a word is in flight; the result strobe lasts one cycle.
// Reset clears the sequencer and insert context; store contents stay undefined.
module bit_field_insert_engine
    import bfi_pkg::*;
(
    input  logic      clk,
    input  logic      rst_n,
    input  logic      start,
    output logic      busy,
    input  in_word_t  cmd,
    output logic      strobe,
    output out_word_t result
);

    state_t    state_reg, state_next;
    plan_t     plan;
    plan_t     plan_reg;
    logic      strobe_reg, strobe_next;
    out_word_t result_reg, result_next;
    logic      accept;
    logic      take;
    logic      wr_en, rd_en;
    addr_t     wr_addr, rd_addr;
    word_t     wr_data, rd_data;
    addr_t     tail_addr;

    assign busy      = (state_reg != S_IDLE);
    assign accept    = start && !busy;
    assign take      = accept && (cmd.op == OP_INSERT);
    assign tail_addr = plan_reg.dest + addr_t'(1);

    bfi_plan u_plan (
        .clk   (clk),
        .rst_n (rst_n),
        .item  (cmd),
        .take  (take),
        .plan  (plan)
    );

    bfi_store u_store (
        .clk     (clk),
        .wr_en   (wr_en),
        .wr_addr (wr_addr),
        .wr_data (wr_data),
        .rd_en   (rd_en),
        .rd_addr (rd_addr),
        .rd_data (rd_data)
    );

    always_comb
    begin
        state_next  = state_reg;
        strobe_next = 1'b0;
        result_next = '0;
        wr_en       = 1'b0;
        wr_addr     = plan_reg.dest;
        wr_data     = (rd_data & ~plan_reg.mask) | (plan_reg.val & plan_reg.mask);
        rd_en       = 1'b0;
        rd_addr     = plan.dest;
        unique case (state_reg)
            S_IDLE:
            begin
                if (accept)
                begin
                    case (cmd.op)
                        OP_WRITE:
                        begin
                            wr_en       = 1'b1;
                            wr_addr     = addr_t'(cmd.word_index);
                            wr_data     = cmd.data[WORD_BITS-1:0];
                            strobe_next = 1'b1;
                        end
                        OP_READ:
                        begin
                            rd_en      = 1'b1;
                            rd_addr    = addr_t'(cmd.word_index);
                            state_next = S_READ;
                        end
                        OP_INSERT:
                        begin
                            if (plan.ok)
                            begin
                                rd_en      = 1'b1;
                                state_next = S_MERGE;
                            end
                            else
                            begin
                                strobe_next       = 1'b1;
                                result_next.error = 1'b1;
                            end
                        end
                        default:
                        begin
                            strobe_next = 1'b1;
                        end
                    endcase
                end
            end
            S_READ:
            begin
                strobe_next           = 1'b1;
                result_next.read_data = 32'(rd_data);
                state_next            = S_IDLE;
            end
            S_MERGE:
            begin
                wr_en = 1'b1;
                if (plan_reg.tail)
                begin
                    rd_en      = 1'b1;
                    rd_addr    = tail_addr;
                    state_next = S_TAIL;
                end
                else
                begin
                    strobe_next             = 1'b1;
                    result_next.insert_done = plan_reg.done;
                    state_next              = S_IDLE;
                end
            end
            S_TAIL:
            begin
                wr_en   = 1'b1;
                wr_addr = tail_addr;
                wr_data = (rd_data & ~plan_reg.tail_mask)
                        | (plan_reg.tail_val & plan_reg.tail_mask);
                strobe_next             = 1'b1;
                result_next.insert_done = 1'b1;
                state_next              = S_IDLE;
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg  <= S_IDLE;
            strobe_reg <= 1'b0;
        end
        else
        begin
            state_reg  <= state_next;
            strobe_reg <= strobe_next;
        end
    end

    always_ff @(posedge clk)
    begin
        result_reg <= result_next;
        if (take)
        begin
            plan_reg <= plan;
        end
    end

    assign strobe = strobe_reg;
    assign result = result_reg;

    a_no_done_with_error: assert property (@(posedge clk) disable iff (!rst_n)
        strobe |-> !(result.insert_done && result.error))
        else $error("insert_done and error together");

    a_accept_progress: assert property (@(posedge clk) disable iff (!rst_n)
        accept |=> (busy || strobe))
        else $error("accepted word neither in flight nor answered");

    a_tail_after_merge: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == S_TAIL) |-> ($past(state_reg) == S_MERGE))
        else $error("trailing word update without merge");

    a_read_answers: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == S_READ) |=> (strobe && !busy))
        else $error("read did not answer");

    a_merge_planned: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == S_MERGE) |-> plan_reg.ok)
        else $error("merge without valid plan");

endmodule

FILE: rtl/bfi_store.sv
// Destination word memory: one write port and one registered read port.
module bfi_store
    import bfi_pkg::*;
(
    input  logic  clk,
    input  logic  wr_en,
    input  addr_t wr_addr,
    input  word_t wr_data,
    input  logic  rd_en,
    input  addr_t rd_addr,
    output word_t rd_data
);

    word_t mem [STORE_WORDS];
    word_t rd_data_reg;

    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            mem[wr_addr] <= wr_data;
        end
    end

    always_ff @(posedge clk)
    begin
        if (rd_en)
        begin
            rd_data_reg <= mem[rd_addr];
        end
    end

    assign rd_data = rd_data_reg;

endmodule

FILE: rtl/bfi_plan.sv
// Insert context registers and the merge plan for each source word.
module bfi_plan
    import bfi_pkg::*;
(
    input  logic     clk,
    input  logic     rst_n,
    input  in_word_t item,
    input  logic     take,
    output plan_t    plan
);

    logic                  open_reg;
    addr_t                 dest_reg;
    logic [SHIFT_BITS-1:0] shift_reg;
    logic [COUNT_BITS-1:0] bits_reg;
    word_t                 carry_reg;

    logic [SHIFT_BITS-1:0] e_shift;
    addr_t                 e_dest;
    logic [COUNT_BITS-1:0] e_bits;
    word_t                 e_carry;
    word_t                 src;
    logic [SPAN_BITS-1:0]  span_end;
    logic [SPAN_BITS-1:0]  hi;
    logic [SHIFT_BITS-1:0] lo;
    logic [2*WORD_BITS-1:0] wide_data;
    logic [2*WORD_BITS-1:0] wide_carry;
    word_t                 hi_mask;
    word_t                 lo_mask;
    logic                  ok;
    logic                  last;

    always_comb
    begin
        src      = item.data[WORD_BITS-1:0];
        e_shift  = item.first ? item.bit_offset[SHIFT_BITS-1:0] : shift_reg;
        e_dest   = item.first ? item.bit_offset[SHIFT_BITS +: ADDR_BITS] : dest_reg;
        e_bits   = item.first ? item.bit_count : bits_reg;
        e_carry  = item.first ? '0 : carry_reg;
        span_end = SPAN_BITS'(item.bit_offset) + SPAN_BITS'(item.bit_count);
        if (item.first)
        begin
            ok = (item.bit_count != '0) && (span_end <= TOTAL_BITS);
        end
        else
        begin
            ok = open_reg;
        end
        hi         = SPAN_BITS'(e_shift) + SPAN_BITS'(e_bits);
        lo         = item.first ? e_shift : '0;
        wide_data  = {{WORD_BITS{1'b0}}, src} << e_shift;
        wide_carry = {{WORD_BITS{1'b0}}, e_carry} << e_shift;
        hi_mask    = (hi >= WORD_SPAN) ? '1 : ((word_t'(1) << hi[SHIFT_BITS-1:0]) - word_t'(1));
        lo_mask    = (word_t'(1) << lo) - word_t'(1);
        last       = SPAN_BITS'(e_bits) <= WORD_SPAN;

        plan.ok        = ok;
        plan.done      = last;
        plan.tail      = last && (hi > WORD_SPAN);
        plan.dest      = e_dest;
        plan.val       = wide_data[WORD_BITS-1:0] | wide_carry[2*WORD_BITS-1:WORD_BITS];
        plan.mask      = hi_mask & ~lo_mask;
        plan.tail_val  = wide_data[2*WORD_BITS-1:WORD_BITS];
        plan.tail_mask = (word_t'(1) << hi[SHIFT_BITS-1:0]) - word_t'(1);
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            open_reg  <= 1'b0;
            dest_reg  <= '0;
            shift_reg <= '0;
            bits_reg  <= '0;
            carry_reg <= '0;
        end
        else if (take)
        begin
            if (!ok)
            begin
                if (item.first)
                begin
                    open_reg <= 1'b0;
                end
            end
            else
            begin
                shift_reg <= e_shift;
                carry_reg <= src;
                if (last)
                begin
                    open_reg <= 1'b0;
                    bits_reg <= '0;
                    dest_reg <= e_dest;
                end
                else
                begin
                    open_reg <= 1'b1;
                    bits_reg <= e_bits - COUNT_BITS'(WORD_BITS);
                    dest_reg <= e_dest + addr_t'(1);
                end
            end
        end
    end

endmodule

FILE: tb/bit_field_insert_checker.sv
`timescale 1ns / 100ps
// Checker for the bit field insert engine: predicts each result word and compares it.
module bit_field_insert_checker
    import bfi_pkg::*;
(
    input  logic      clk,
    input  logic      rst_n,
    input  logic      start,
    input  logic      busy,
    input  in_word_t  cmd,
    input  logic      strobe,
    input  out_word_t result,
    output int        fails,
    output int        pending
);

    word_t     store [STORE_WORDS];
    word_t     carry     = '0;
    int        dest_word = 0;
    int        shift     = 0;
    int        bits_left = 0;
    logic      open_ins  = 1'b0;
    int        miscount  = 0;
    out_word_t want;
    out_word_t due_words [$];

    function automatic word_t span_mask(int lo, int hi);
        logic [63:0] m;
        if (hi > WORD_BITS)
            hi = WORD_BITS;
        if (lo >= hi)
            return '0;
        m = ((64'd1 << hi) - 64'd1) & ~((64'd1 << lo) - 64'd1);
        return word_t'(m);
    endfunction

    function automatic void merge(int idx, word_t val, word_t m);
        if (m != '0 && idx < STORE_WORDS)
            store[idx] = (store[idx] & ~m) | (val & m);
    endfunction

    function automatic out_word_t engine_step(in_word_t c);
        out_word_t r;
        word_t     val;
        int        hi;
        logic      ok;
        r = '0;
        case (op_t'(c.op))
            OP_WRITE:
                store[c.word_index] = c.data;
            OP_READ:
                r.read_data = store[c.word_index];
            OP_INSERT:
            begin
                ok = 1'b1;
                if (c.first)
                begin
                    open_ins = 1'b0;
                    if (c.bit_count == 0
                        || int'(c.bit_offset) + int'(c.bit_count) > WORD_BITS * STORE_WORDS)
                        ok = 1'b0;
                    else
                    begin
                        open_ins  = 1'b1;
                        dest_word = int'(c.bit_offset) / WORD_BITS;
                        shift     = int'(c.bit_offset) % WORD_BITS;
                        bits_left = int'(c.bit_count);
                        carry     = '0;
                    end
                end
                else if (!open_ins)
                    ok = 1'b0;
                if (!ok)
                    r.error = 1'b1;
                else
                begin
                    hi  = shift + bits_left;
                    val = c.data << shift;
                    if (shift != 0)
                        val |= carry >> (WORD_BITS - shift);
                    merge(dest_word, val, span_mask(c.first ? shift : 0, hi));
                    if (bits_left <= WORD_BITS)
                    begin
                        if (hi > WORD_BITS && shift != 0)
                            merge(dest_word + 1, c.data >> (WORD_BITS - shift),
                                  span_mask(0, hi - WORD_BITS));
                        open_ins      = 1'b0;
                        bits_left     = 0;
                        r.insert_done = 1'b1;
                    end
                    else
                    begin
                        bits_left -= WORD_BITS;
                        dest_word++;
                    end
                    carry = c.data;
                end
            end
            OP_NONE: ;
            default: ;
        endcase
        return r;
    endfunction

    function automatic void check_field(string name, logic [31:0] exp_v, logic [31:0] got_v);
        if (got_v !== exp_v)
        begin
            $error("%s mismatch: expected %h actual %h", name, exp_v, got_v);
            miscount++;
        end
    endfunction

    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            carry     = '0;
            dest_word = 0;
            shift     = 0;
            bits_left = 0;
            open_ins  = 1'b0;
            due_words.delete();
        end
        else
        begin
            if (strobe)
            begin
                if (due_words.size() == 0)
                begin
                    $error("result word with nothing outstanding: %p", result);
                    miscount++;
                end
                else
                begin
                    want = due_words.pop_front();
                    check_field("read_data", want.read_data, result.read_data);
                    check_field("insert_done", 32'(want.insert_done), 32'(result.insert_done));
                    check_field("error", 32'(want.error), 32'(result.error));
                end
            end
            if (start && !busy)
                due_words.push_back(engine_step(cmd));
        end
        fails   <= miscount;
        pending <= due_words.size();
    end

endmodule

FILE: tb/bit_field_insert_engine_tb.sv
`timescale 1ns / 100ps
// Testbench top for the bit field insert engine: stimulus, watchdog and verdict.
module bit_field_insert_engine_tb
    import bfi_pkg::*;
();

    localparam int FIELD_BITS  = WORD_BITS * STORE_WORDS;
    localparam int RUN_WORDS   = 1550;
    localparam int CALM_WORDS  = 200;
    localparam int STALL_LIMIT = 2000;

    logic      clk   = 1'b0;
    logic      rst_n = 1'b0;
    logic      start = 1'b0;
    in_word_t  cmd   = '0;
    logic      busy;
    logic      strobe;
    out_word_t result;
    int        fails;
    int        pending;
    int        sent     = 0;
    int        stall    = 0;
    int        gap_odds = 2;
    bit        written [STORE_WORDS];

    always #2 clk = ~clk;

    bit_field_insert_engine DUT (
        .clk    (clk),
        .rst_n  (rst_n),
        .start  (start),
        .busy   (busy),
        .cmd    (cmd),
        .strobe (strobe),
        .result (result)
    );

    bit_field_insert_checker u_check (
        .clk     (clk),
        .rst_n   (rst_n),
        .start   (start),
        .busy    (busy),
        .cmd     (cmd),
        .strobe  (strobe),
        .result  (result),
        .fails   (fails),
        .pending (pending)
    );

    always @(posedge clk)
    begin
        if (start && !busy)
            stall <= 0;
        else
            stall <= stall + 1;
        if (stall >= STALL_LIMIT)
        begin
            $display("TEST FAILED");
            $finish;
        end
    end

    task automatic idle(int n);
        @(negedge clk);
        start = 1'b0;
        repeat (n - 1) @(negedge clk);
    endtask

    task automatic issue(op_t op, int idx, word_t d, int offs, int cnt, bit fst);
        in_word_t w;
        if (sent % 64 == 0)
            gap_odds = $urandom_range(0, 4);
        if (sent < RUN_WORDS - CALM_WORDS && gap_odds != 0 && $urandom_range(1, 8) <= gap_odds)
            idle($urandom_range(1, 12));
        w.op         = op;
        w.word_index = 8'(idx);
        w.data       = d;
        w.bit_offset = OFFSET_BITS'(offs);
        w.bit_count  = COUNT_BITS'(cnt);
        w.first      = fst;
        @(negedge clk);
        cmd   = w;
        start = 1'b1;
        @(posedge clk);
        while (busy)
            @(posedge clk);
        sent++;
        if (op == OP_WRITE)
            written[idx] = 1'b1;
    endtask

    task automatic put(int idx, word_t d);
        issue(OP_WRITE, idx, d, $urandom_range(0, 8191), $urandom_range(0, 16383), 1'($urandom));
    endtask

    task automatic get(int idx);
        issue(OP_READ, idx, $urandom(), $urandom_range(0, 8191), $urandom_range(0, 16383),
              1'($urandom));
    endtask

    function automatic int pick_written();
        int i;
        do
            i = $urandom_range(0, STORE_WORDS - 1);
        while (!written[i]);
        return i;
    endfunction

    task automatic insert_field(int offs, int cnt, bit cut);
        int n;
        int stop;
        for (int w = offs / WORD_BITS; w <= (offs + cnt - 1) / WORD_BITS; w++)
            if (!written[w])
                put(w, $urandom());
        n    = (cnt + WORD_BITS - 1) / WORD_BITS;
        stop = cut ? $urandom_range(1, n) : n;
        for (int k = 0; k < stop; k++)
        begin
            if (k == 0)
                issue(OP_INSERT, $urandom_range(0, 255), $urandom(), offs, cnt, 1'b1);
            else
                issue(OP_INSERT, $urandom_range(0, 255), $urandom(), $urandom_range(0, 8191),
                      $urandom_range(0, 16383), 1'b0);
            if ($urandom_range(0, 15) == 0)
            begin
                if ($urandom_range(0, 1) == 0)
                    put($urandom_range(0, STORE_WORDS - 1), $urandom());
                else
                    get(pick_written());
            end
        end
    endtask

    initial
    begin
        int pick;
        int cnt;
        int offs;

        repeat (10) @(posedge clk);
        @(negedge clk);
        rst_n = 1'b1;

        // source word with no insert open, then the unused op with every field high
        issue(OP_INSERT, 0, '1, 0, 32, 1'b0);
        issue(OP_NONE, 255, '1, 8191, 16383, 1'b1);
        put(0, '0);
        put(1, 32'hA5A5_A5A5);
        put(2, 32'h0F0F_F0F0);
        put(STORE_WORDS - 2, 32'h5A5A_5A5A);
        put(STORE_WORDS - 1, '1);
        get(STORE_WORDS - 1);
        get(0);
        issue(OP_INSERT, 0, '1, 0, WORD_BITS, 1'b1);
        // spill into the trailing word on the last source word
        issue(OP_INSERT, 0, 32'h1234_5678, 8, 60, 1'b1);
        issue(OP_INSERT, 0, '1, 0, 0, 1'b0);
        issue(OP_INSERT, 0, 32'h8000_0001, FIELD_BITS - 1, 1, 1'b1);
        issue(OP_INSERT, 0, '1, FIELD_BITS - 1, 2, 1'b1);
        issue(OP_INSERT, 0, '1, 100, 0, 1'b1);
        // open an insert, read in the middle, then abandon it with a new first word
        issue(OP_INSERT, 0, 32'hDEAD_BEEF, 40, 100, 1'b1);
        get(1);
        issue(OP_INSERT, 0, 32'hCAFE_F00D, 33, 3, 1'b1);
        issue(OP_INSERT, 0, '1, 0, 0, 1'b0);
        get(0);
        get(1);
        get(2);
        get(STORE_WORDS - 2);
        get(STORE_WORDS - 1);

        while (sent < RUN_WORDS)
        begin
            pick = $urandom_range(0, 99);
            if (pick < 40)
            begin
                if ($urandom_range(0, 199) == 0)
                    cnt = $urandom_range(1, FIELD_BITS);
                else
                    cnt = $urandom_range(1, 160);
                insert_field($urandom_range(0, FIELD_BITS - cnt), cnt, $urandom_range(0, 7) == 0);
            end
            else if (pick < 58)
                put($urandom_range(0, STORE_WORDS - 1), $urandom());
            else if (pick < 76)
                get(pick_written());
            else if (pick < 82)
                issue(OP_NONE, $urandom_range(0, 255), $urandom(), $urandom_range(0, 8191),
                      $urandom_range(0, 16383), 1'($urandom));
            else if (pick < 92)
            begin
                cnt = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(2, 16383);
                if (cnt == 0 || cnt > FIELD_BITS)
                    offs = $urandom_range(0, 8191);
                else
                    offs = $urandom_range(FIELD_BITS + 1 - cnt, 8191);
                issue(OP_INSERT, $urandom_range(0, 255), $urandom(), offs, cnt, 1'b1);
            end
            else
                issue(OP_INSERT, $urandom_range(0, 255), $urandom(), $urandom_range(0, 8191),
                      $urandom_range(0, 16383), 1'b0);
        end

        @(negedge clk);
        start = 1'b0;
        while (pending != 0)
            @(posedge clk);
        repeat (10) @(posedge clk);
        if (fails == 0 && pending == 0)
            $display("TEST PASSED");
        else
            $display("TEST FAILED");
        $finish;
    end

endmodule

FILE: sim.f
rtl/bfi_pkg.sv
rtl/bfi_store.sv
rtl/bfi_plan.sv
rtl/bit_field_insert_engine.sv
tb/bit_field_insert_checker.sv
tb/bit_field_insert_engine_tb.sv
